/* hdl/ncl_pkg.sv */
// Shared types and constants for the nearest codebook lookup block.
`default_nettype none

package ncl_pkg;

    localparam int VALUE_W = 32;
    localparam int CODE_W  = 12;
    localparam int INDEX_W = 12;
    localparam int SIZE_W  = 13;
    localparam int ENTRY_W = VALUE_W + CODE_W;

    // Request kinds carried on req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SEL,
        S_LOW,
        S_HIGH
    } t_state;

endpackage

`default_nettype wire

/* hdl/nearest_codebook_lookup.sv */
// Top level: scalar quantizer that binary-searches a sorted codebook memory.
`default_nettype none

// Channel   Handshake                    Payload
// -------   --------------------------   ----------------------------------------------
// in        i_in_valid / o_in_ready      i_req_type, i_entry_index, i_entry_value,
//                                        i_entry_code, i_query_value
// out       o_out_valid / i_out_ready    o_code_id
// cfg       i_cfg_we (no wait)           i_cfg_wdata (table_size)
//
// A load writes the entry at the transfer and leaves the block ready for the next item.
// A query repeats search probes (address the codebook memory, then compare the registered
// read data), then leaves the search, addresses the lower neighbor, holds it and compares
// with the upper neighbor before the result is presented. A query below the first or past
// the last entry skips the upper fetch. The single read port of the codebook memory and
// the one shared compare serialize these steps, so a new item is taken only once the
// query is done.
// Reset is synchronous, active low; it clears the sequencer, the output valid and sets
// table_size to 1. The codebook memory is not cleared.
// A stalled output holds the finished code; the sequencer waits in its last step until the
// output register is free, so no result is lost.

module nearest_codebook_lookup
    import ncl_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [SIZE_W-1:0]         i_cfg_wdata,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_req_type,
    input  wire logic [INDEX_W-1:0]        i_entry_index,
    input  wire logic signed [VALUE_W-1:0] i_entry_value,
    input  wire logic [CODE_W-1:0]         i_entry_code,
    input  wire logic signed [VALUE_W-1:0] i_query_value,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [CODE_W-1:0]              o_code_id
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    // Codebook memory: value in the upper bits, code in the lower bits
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    t_state r_state, n_state;

    logic [SIZE_W-1:0]         r_table_size;
    logic [SW-1:0]             r_lo, n_lo;
    logic [SW-1:0]             r_hi, n_hi;
    logic [SW-1:0]             r_n, n_n;
    logic signed [VALUE_W-1:0] r_query, n_query;
    logic signed [VALUE_W-1:0] r_low_value, n_low_value;
    logic [CODE_W-1:0]         r_low_code, n_low_code;
    logic                      r_out_valid, n_out_valid;
    logic [CODE_W-1:0]         r_out_code, n_out_code;
    logic [ENTRY_W-1:0]        r_rd_data;

    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic [31:0]               w_idx_ext;
    logic                      w_idx_ok;
    logic [31:0]               w_size_ext;
    logic [31:0]               w_n_full;
    logic [SW-1:0]             w_n;
    logic [SW-1:0]             w_mid;
    logic [SW-1:0]             w_mid_inc;
    logic [SW-1:0]             w_lo_dec;
    logic [SW-1:0]             w_n_dec;
    logic signed [VALUE_W-1:0] w_rd_value;
    logic [CODE_W-1:0]         w_rd_code;
    logic signed [VALUE_W+1:0] w_twice_q;
    logic signed [VALUE_W+1:0] w_pair_sum;
    logic                      w_pick_low;
    logic                      w_pair;
    logic                      w_out_free;

    // Load address; drop loads beyond the table
    assign w_idx_ext = 32'(i_entry_index);
    assign w_idx_ok  = w_idx_ext < 32'(TABLE_DEPTH);
    assign w_wr_addr = w_idx_ext[AW-1:0];

    // Active size: zero counts as one, clamp to the table depth
    assign w_size_ext = 32'(r_table_size);
    always_comb begin
        priority if (w_size_ext == 32'd0) begin
            w_n_full = 32'd1;
        end else if (w_size_ext > 32'(TABLE_DEPTH)) begin
            w_n_full = 32'(TABLE_DEPTH);
        end else begin
            w_n_full = w_size_ext;
        end
    end
    assign w_n = w_n_full[SW-1:0];

    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_mid_inc = w_mid + SW'(1);
    assign w_lo_dec  = r_lo - SW'(1);
    assign w_n_dec   = r_n - SW'(1);

    assign w_rd_value = r_rd_data[ENTRY_W-1:CODE_W];
    assign w_rd_code  = r_rd_data[CODE_W-1:0];

    // Lower neighbor wins only when strictly nearer: 2q < upper + lower
    assign w_twice_q  = {r_query[VALUE_W-1], r_query, 1'b0};
    assign w_pair_sum = (VALUE_W+2)'(w_rd_value) + (VALUE_W+2)'(r_low_value);
    assign w_pick_low = w_twice_q < w_pair_sum;

    // Two neighbors exist unless the query falls below the first or past the last entry
    assign w_pair     = (r_lo != '0) && (r_lo != r_n);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_n         = r_n;
        n_query     = r_query;
        n_low_value = r_low_value;
        n_low_code  = r_low_code;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_code  = r_out_code;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_QUERY) begin
                        n_query = i_query_value;
                        n_lo    = '0;
                        n_hi    = w_n;
                        n_n     = w_n;
                        n_state = S_PROBE;
                    end else begin
                        w_wr_en = w_idx_ok;
                    end
                end
            end
            S_PROBE: begin
                // Address the middle entry, or leave the search when the range is empty
                if (r_lo < r_hi) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_mid[AW-1:0];
                    n_state   = S_CMP;
                end else begin
                    n_state = S_SEL;
                end
            end
            S_CMP: begin
                if (w_rd_value <= r_query) begin
                    n_lo = w_mid_inc;
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_PROBE;
            end
            S_SEL: begin
                w_rd_en = 1'b1;
                priority if (r_lo == '0) begin
                    w_rd_addr = '0;
                end else if (r_lo == r_n) begin
                    w_rd_addr = w_n_dec[AW-1:0];
                end else begin
                    w_rd_addr = w_lo_dec[AW-1:0];
                end
                n_state = S_LOW;
            end
            S_LOW: begin
                if (w_pair) begin
                    // Hold the lower neighbor, fetch the upper one
                    n_low_value = w_rd_value;
                    n_low_code  = w_rd_code;
                    w_rd_en     = 1'b1;
                    w_rd_addr   = r_lo[AW-1:0];
                    n_state     = S_HIGH;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = w_rd_code;
                    n_state     = S_IDLE;
                end
            end
            S_HIGH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = w_pick_low ? r_low_code : w_rd_code;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_table_size <= SIZE_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    // Search and payload registers
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_n         <= n_n;
        r_query     <= n_query;
        r_low_value <= n_low_value;
        r_low_code  <= n_low_code;
        r_out_code  <= n_out_code;
    end

    // Codebook memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= {i_entry_value, i_entry_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_id   = r_out_code;

    // The search range stays ordered and inside the active size
    a_range_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CMP || r_state == S_SEL)
            |-> (r_lo <= r_hi && r_hi <= r_n))
        else $error("search range out of order");

    // No new item while a query is being searched
    a_busy_not_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready during a query");

    // The final step of a pair compare presents a result once the output register is free
    a_pair_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIGH && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("pair compare gave no result");

endmodule

`default_nettype wire
